// ===== hdl/rv32_subset_decode_execute_defines.svh =====
// Assertion macros used by the checker file.
`ifndef RV32_SUBSET_DECODE_EXECUTE_DEFINES_SVH
`define RV32_SUBSET_DECODE_EXECUTE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RSDE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RSDE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rsde_pkg.sv =====
`timescale 1ns / 1ps

package rsde_pkg;

  localparam logic [6:0] OPC_R     = 7'b0110011;
  localparam logic [6:0] OPC_I     = 7'b0010011;
  localparam logic [6:0] OPC_BR    = 7'b1100011;
  localparam logic [6:0] OPC_JALR  = 7'b1100111;
  localparam logic [6:0] OPC_LOAD  = 7'b0000011;
  localparam logic [6:0] OPC_STORE = 7'b0100011;
  localparam logic [6:0] OPC_LUI   = 7'b0110111;

  localparam logic [2:0] F3_ADD  = 3'b000;
  localparam logic [2:0] F3_SLTU = 3'b011;
  localparam logic [2:0] F3_SRA  = 3'b101;
  localparam logic [2:0] F3_OR   = 3'b110;
  localparam logic [2:0] F3_AND  = 3'b111;

  typedef enum logic [2:0] {
    ALU_ADD  = 3'd0,
    ALU_SUB  = 3'd1,
    ALU_OR   = 3'd2,
    ALU_AND  = 3'd3,
    ALU_SRA  = 3'd4,
    ALU_SLTU = 3'd5,
    ALU_LUI  = 3'd6
  } alu_op_t;

  typedef struct packed {
    logic [31:0]        instr;
    logic signed [31:0] rs1_value;
    logic signed [31:0] rs2_value;
  } in_t;

  typedef struct packed {
    logic [4:0]         rs1_index;
    logic [4:0]         rs2_index;
    logic [4:0]         rd_index;
    logic signed [19:0] imm;
    logic               reg_write;
    logic               mem_read;
    logic               mem_write;
    logic               mem_to_reg;
    logic               branch;
    logic signed [31:0] alu_result;
    logic               zero;
    logic               illegal;
  } out_t;

  // Decoder to ALU control
  typedef struct packed {
    alu_op_t     op;
    logic        sel_rs2;   // second operand is rs2_value, else the immediate
    logic [31:0] imm;
    logic        illegal;
  } alu_ctrl_t;

  // Decoder fields that go straight to the result
  typedef struct packed {
    logic [4:0]  rs1_index;
    logic [4:0]  rs2_index;
    logic [4:0]  rd_index;
    logic [19:0] imm;
    logic        reg_write;
    logic        mem_read;
    logic        mem_write;
    logic        mem_to_reg;
    logic        branch;
    logic        illegal;
  } dec_fields_t;

endpackage

// ===== hdl/rsde_decode.sv =====
`timescale 1ns / 1ps

module rsde_decode
  import rsde_pkg::*;
(
  input  logic [31:0] instr,
  output dec_fields_t fields,
  output alu_ctrl_t   ctrl
);

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_u;
  logic [31:0] imm;
  logic        rw, mr, mw, br, use_rs1, use_rs2, bad;
  alu_op_t     op;

  assign opc = instr[6:0];
  assign f3  = instr[14:12];
  assign f7  = instr[31:25];

  assign imm_i = {{20{instr[31]}}, instr[31:20]};
  assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
  // halfword offset without the trailing zero bit
  assign imm_b = {{20{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8]};
  assign imm_u = {{12{instr[31]}}, instr[31:12]};

  always_comb begin
    rw      = 1'b0;
    mr      = 1'b0;
    mw      = 1'b0;
    br      = 1'b0;
    use_rs1 = 1'b1;
    use_rs2 = 1'b0;
    bad     = 1'b0;
    imm     = '0;
    op      = ALU_ADD;
    unique case (opc)
      OPC_R: begin
        rw      = 1'b1;
        use_rs2 = 1'b1;
        unique case (f3)
          F3_ADD:  op = (f7 != 7'd0) ? ALU_SUB : ALU_ADD;
          F3_OR:   op = ALU_OR;
          F3_AND:  op = ALU_AND;
          F3_SRA:  op = ALU_SRA;
          default: bad = 1'b1;
        endcase
      end
      OPC_I: begin
        rw  = 1'b1;
        imm = imm_i;
        unique case (f3)
          F3_ADD:  op = ALU_ADD;
          F3_OR:   op = ALU_OR;
          F3_AND:  op = ALU_AND;
          F3_SLTU: op = ALU_SLTU;
          default: bad = 1'b1;
        endcase
      end
      OPC_BR: begin
        br      = 1'b1;
        use_rs2 = 1'b1;
        op      = ALU_SUB;
        imm     = imm_b;
      end
      OPC_JALR: begin
        rw  = 1'b1;
        br  = 1'b1;
        imm = {20'd0, instr[31:20]};
      end
      OPC_LOAD: begin
        rw  = 1'b1;
        mr  = 1'b1;
        imm = imm_i;
      end
      OPC_STORE: begin
        mw      = 1'b1;
        use_rs2 = 1'b1;
        imm     = imm_s;
      end
      OPC_LUI: begin
        rw      = 1'b1;
        use_rs1 = 1'b0;
        op      = ALU_LUI;
        imm     = imm_u;
      end
      default: bad = 1'b1;
    endcase
  end

  always_comb begin
    if (bad) begin
      fields         = '0;
      fields.illegal = 1'b1;
    end else begin
      fields.rs1_index  = use_rs1 ? instr[19:15] : 5'd0;
      fields.rs2_index  = use_rs2 ? instr[24:20] : 5'd0;
      fields.rd_index   = rw ? instr[11:7] : 5'd0;
      fields.imm        = imm[19:0];
      fields.reg_write  = rw;
      fields.mem_read   = mr;
      fields.mem_write  = mw;
      fields.mem_to_reg = mr;
      fields.branch     = br;
      fields.illegal    = 1'b0;
    end
  end

  assign ctrl.op      = op;
  assign ctrl.sel_rs2 = (opc == OPC_R) || (opc == OPC_BR);
  assign ctrl.imm     = imm;
  assign ctrl.illegal = bad;

endmodule

// ===== hdl/rsde_alu.sv =====
`timescale 1ns / 1ps

module rsde_alu
  import rsde_pkg::*;
(
  input  logic [31:0] rs1_value,
  input  logic [31:0] rs2_value,
  input  alu_ctrl_t   ctrl,
  output logic [31:0] result,
  output logic        zero
);

  logic [31:0] opnd;
  logic [31:0] diff;
  logic [31:0] res;

  assign opnd = ctrl.sel_rs2 ? rs2_value : ctrl.imm;
  assign diff = rs1_value - opnd;

  always_comb begin
    unique case (ctrl.op)
      ALU_ADD:  res = rs1_value + opnd;
      ALU_SUB:  res = diff;
      ALU_OR:   res = rs1_value | opnd;
      ALU_AND:  res = rs1_value & opnd;
      ALU_SRA:  res = $unsigned($signed(rs1_value) >>> opnd[4:0]);
      ALU_SLTU: res = {31'd0, (rs1_value < opnd)};
      ALU_LUI:  res = {ctrl.imm[19:0], 12'd0};
      default:  res = '0;
    endcase
  end

  assign result = ctrl.illegal ? 32'd0 : res;
  assign zero   = !ctrl.illegal && (ctrl.op == ALU_SUB) && (diff == 32'd0);

endmodule

// ===== hdl/rv32_subset_decode_execute.sv =====
`timescale 1ns / 1ps

// RV32 subset decode and execute. Each instruction transfer on cmd
// (instruction word plus both source values) produces one result transfer on
// rsp, carrying the register indices, immediate, control bits, ALU result,
// zero flag and illegal flag. One instruction is taken
// every cycle: decode and ALU sit between an input register and a result
// register, and each register is released as soon as the next stage can take
// its contents, so rsp_stall throttles cmd only while both registers are full.
// Unsupported opcodes, and unsupported funct3 codes of R-type and I-type
// instructions, give illegal = 1 with every other field 0.
module rv32_subset_decode_execute
  import rsde_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  in_t  cmd,
  output logic rsp_valid,
  input  logic rsp_stall,
  output out_t rsp
);

  logic        cmd_full;
  in_t         cmd_q;
  logic        rsp_ready;
  dec_fields_t fields;
  alu_ctrl_t   ctrl;
  logic [31:0] result;
  logic        zero;
  out_t        rsp_next;

  assign rsp_ready = !rsp_valid || !rsp_stall;
  assign cmd_stall = cmd_full && !rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_full  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (!cmd_stall) cmd_full <= cmd_valid;
      if (rsp_ready) rsp_valid <= cmd_full;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) cmd_q <= cmd;
    if (rsp_ready && cmd_full) rsp <= rsp_next;
  end

  rsde_decode u_decode (
    .instr  (cmd_q.instr),
    .fields (fields),
    .ctrl   (ctrl)
  );

  rsde_alu u_alu (
    .rs1_value (cmd_q.rs1_value),
    .rs2_value (cmd_q.rs2_value),
    .ctrl      (ctrl),
    .result    (result),
    .zero      (zero)
  );

  always_comb begin
    rsp_next.rs1_index  = fields.rs1_index;
    rsp_next.rs2_index  = fields.rs2_index;
    rsp_next.rd_index   = fields.rd_index;
    rsp_next.imm        = fields.imm;
    rsp_next.reg_write  = fields.reg_write;
    rsp_next.mem_read   = fields.mem_read;
    rsp_next.mem_write  = fields.mem_write;
    rsp_next.mem_to_reg = fields.mem_to_reg;
    rsp_next.branch     = fields.branch;
    rsp_next.alu_result = result;
    rsp_next.zero       = zero;
    rsp_next.illegal    = fields.illegal;
  end

endmodule

// ===== hdl/rsde_checker.sv =====
`timescale 1ns / 1ps
`include "rv32_subset_decode_execute_defines.svh"

module rsde_props
  import rsde_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input out_t rsp
);

  // a stalled result transfer holds
  `RSDE_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp changed while stalled")

  // illegal results carry nothing else
  `RSDE_ASSERT_IMP(a_illegal_clean, clk, rst, rsp_valid && rsp.illegal, rsp.alu_result == 32'sd0 && rsp.imm == 20'sd0 && !rsp.reg_write && !rsp.branch && !rsp.mem_read && !rsp.mem_write && rsp.rs1_index == 5'd0, "illegal result has nonzero fields")

  // zero flag only with a zero result
  `RSDE_ASSERT_IMP(a_zero_flag, clk, rst, rsp_valid && rsp.zero, rsp.alu_result == 32'sd0, "zero set on nonzero result")

  // no destination without a register write
  `RSDE_ASSERT_IMP(a_rd_gated, clk, rst, rsp_valid && !rsp.reg_write, rsp.rd_index == 5'd0, "rd_index set without reg_write")

  // input is held off only behind a waiting, stalled result
  `RSDE_ASSERT_IMP(a_stall_backs, clk, rst, cmd_stall, rsp_valid && rsp_stall, "cmd stalled with result side free")

endmodule

bind rv32_subset_decode_execute rsde_props u_rsde_props (.*);
